FILE: rtl/assert_macros.svh
// Assertion helpers shared by the scheduler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define PTRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PTRS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/ptrs_pkg.sv
package ptrs_pkg;

    localparam int SLOT_W    = 3;
    localparam int MAX_TASKS = 1 << SLOT_W;
    localparam int LEN_W     = $clog2(MAX_TASKS + 1);
    localparam int PERIOD_W  = 16;
    localparam int PRIO_W    = 8;
    localparam int CMD_W     = 3;
    localparam int TASK_W    = PERIOD_W + PRIO_W;

    // The divider retires two quotient bits per cycle.
    localparam int DIV_CYCLES = PERIOD_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TASKS);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK, CMD_START, CMD_DELETE, CMD_SUSPEND, CMD_RESUME, CMD_SCHEDULE
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK, ST_INACTIVE, ST_STARTED, ST_UNLISTED
    } t_status;

    typedef enum logic [2:0] {
        W_START, W_DELETE, W_MAX, W_TICK, W_SCHED
    } t_walk;

    typedef enum logic [3:0] {
        S_IDLE, S_DEL_RD, S_DEL_PER, S_LIM, S_LIM_W, S_WALK_RD, S_WALK_ORD,
        S_WALK_TSK, S_DIV_TT, S_DIV_MOD, S_DN_RD, S_DN_WR, S_INSERT, S_UP_RD,
        S_UP_WR, S_EMIT
    } t_state;

    typedef struct packed {
        t_status             status;
        logic                dispatched;
        logic [SLOT_W-1:0]   task_slot;
        logic                last;
    } t_result;

    typedef struct packed {
        logic                start;
        logic [PERIOD_W-1:0] dividend;
        logic [PERIOD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [PERIOD_W-1:0] quot;
        logic [PERIOD_W-1:0] rem;
    } t_div_rsp;

endpackage

FILE: rtl/ptrs_div.sv
module ptrs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptrs_pkg::t_div_req i_req,
    output ptrs_pkg::t_div_rsp o_rsp
);
    import ptrs_pkg::*;

    `include "assert_macros.svh"

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PERIOD_W-1:0]  r_quo;
    logic [PERIOD_W-1:0]  r_rem;
    logic [PERIOD_W-1:0]  r_div;
    logic [PERIOD_W-1:0]  n_quo;
    logic [PERIOD_W-1:0]  n_rem;

    // Two restoring steps per cycle.
    always_comb begin
        logic [PERIOD_W:0]   v_sh;
        logic [PERIOD_W-1:0] v_rem;
        logic [PERIOD_W-1:0] v_quo;
        v_rem = r_rem;
        v_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            v_sh  = {v_rem, v_quo[PERIOD_W-1]};
            v_quo = {v_quo[PERIOD_W-2:0], 1'b0};
            if (v_sh >= {1'b0, r_div}) begin
                v_sh     = v_sh - {1'b0, r_div};
                v_quo[0] = 1'b1;
            end
            v_rem = v_sh[PERIOD_W-1:0];
        end
        n_quo = v_quo;
        n_rem = v_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

    `PTRS_ASSERT(a_no_restart, i_req.start |-> !r_busy, "divider started while busy")

endmodule

FILE: rtl/ptrs_core.sv
module ptrs_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ptrs_pkg::CMD_W-1:0]    i_cmd,
    input  logic [ptrs_pkg::SLOT_W-1:0]   i_slot,
    input  logic [ptrs_pkg::PERIOD_W-1:0] i_period,
    input  logic [ptrs_pkg::PRIO_W-1:0]   i_prio,
    input  logic [ptrs_pkg::PERIOD_W-1:0] i_tick_period,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output ptrs_pkg::t_result             o_res,
    output ptrs_pkg::t_div_req            o_div,
    input  ptrs_pkg::t_div_rsp            i_div
);
    import ptrs_pkg::*;

    `include "assert_macros.svh"

    t_state r_state;
    t_state n_state;
    t_walk  r_walk;

    logic [LEN_W-1:0]     r_idx;
    logic [LEN_W-1:0]     r_pos;
    logic [LEN_W-1:0]     r_len;
    logic [SLOT_W-1:0]    r_cur;
    logic [SLOT_W-1:0]    r_slot;
    logic [PERIOD_W-1:0]  r_per;
    logic [PRIO_W-1:0]    r_pri;
    logic [PERIOD_W-1:0]  r_tp;
    logic [PERIOD_W-1:0]  r_tick_cnt;
    logic [PERIOD_W-1:0]  r_limit;
    logic [PERIOD_W-1:0]  r_max;
    logic [MAX_TASKS-1:0] r_active;
    logic [MAX_TASKS-1:0] r_susp;
    logic [MAX_TASKS-1:0] r_ready;
    t_result              r_res;
    logic                 r_pend_valid;
    logic [SLOT_W-1:0]    r_pend_slot;

    logic [SLOT_W-1:0]    r_order_mem [MAX_TASKS];
    logic [TASK_W-1:0]    r_task_mem  [MAX_TASKS];
    logic [SLOT_W-1:0]    r_ord_q;
    logic [TASK_W-1:0]    r_task_q;

    logic [SLOT_W-1:0]    w_ord_raddr;
    logic [SLOT_W-1:0]    w_ord_waddr;
    logic [SLOT_W-1:0]    w_ord_wdata;
    logic                 w_ord_we;
    logic [SLOT_W-1:0]    w_task_raddr;
    logic                 w_task_we;
    logic [LEN_W-1:0]     w_idx_dec;
    logic [LEN_W-1:0]     w_idx_inc;
    logic [PERIOD_W-1:0]  w_q_period;
    logic [PRIO_W-1:0]    w_q_prio;
    logic [PERIOD_W-1:0]  w_tt;
    logic                 w_walk_end;
    t_cmd                 w_cmd;
    t_status              w_idle_st;

    assign w_cmd      = t_cmd'(i_cmd);
    assign w_idx_dec  = r_idx - 1'b1;
    assign w_idx_inc  = r_idx + 1'b1;
    assign w_q_period = r_task_q[TASK_W-1:PRIO_W];
    assign w_q_prio   = r_task_q[PRIO_W-1:0];
    assign w_tt       = (i_div.quot == '0) ? PERIOD_W'(1) : i_div.quot;
    assign w_walk_end = (r_idx == r_len);

    // Status of a command as judged when it is taken from the idle state.
    always_comb begin
        priority if (w_cmd == CMD_START && (r_active[i_slot] || r_len >= LEN_MAX)) begin
            w_idle_st = ST_STARTED;
        end else if ((w_cmd == CMD_DELETE || w_cmd == CMD_SUSPEND || w_cmd == CMD_RESUME)
                     && !r_active[i_slot]) begin
            w_idle_st = ST_INACTIVE;
        end else begin
            w_idle_st = ST_OK;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (w_cmd)
                        CMD_TICK:     n_state = S_LIM;
                        CMD_START:    n_state = (r_active[i_slot] || r_len >= LEN_MAX)
                                                ? S_EMIT : S_WALK_RD;
                        CMD_DELETE:   n_state = r_active[i_slot] ? S_DEL_RD : S_EMIT;
                        CMD_SCHEDULE: n_state = S_WALK_RD;
                        default:      n_state = S_EMIT;
                    endcase
                end
            end
            S_DEL_RD:  n_state = S_DEL_PER;
            S_DEL_PER: n_state = S_WALK_RD;
            S_LIM:     n_state = S_LIM_W;
            S_LIM_W:   n_state = i_div.done ? S_WALK_RD : S_LIM_W;
            S_WALK_RD: begin
                if (!w_walk_end) begin
                    n_state = S_WALK_ORD;
                end else if (r_walk == W_START) begin
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_WALK_ORD: begin
                unique case (r_walk)
                    W_DELETE: n_state = (r_ord_q == r_slot) ? S_UP_RD : S_WALK_RD;
                    W_SCHED:  n_state = (r_ready[r_ord_q] && r_pend_valid)
                                        ? S_EMIT : S_WALK_RD;
                    default:  n_state = S_WALK_TSK;
                endcase
            end
            S_WALK_TSK: begin
                unique case (r_walk)
                    W_START: n_state = (w_q_prio > r_pri) ? S_DN_RD : S_WALK_RD;
                    W_TICK:  n_state = S_DIV_TT;
                    default: n_state = S_WALK_RD;
                endcase
            end
            S_DIV_TT:  n_state = i_div.done ? S_DIV_MOD : S_DIV_TT;
            S_DIV_MOD: n_state = i_div.done ? S_WALK_RD : S_DIV_MOD;
            S_DN_RD:   n_state = (r_idx == r_pos) ? S_INSERT : S_DN_WR;
            S_DN_WR:   n_state = S_DN_RD;
            S_INSERT:  n_state = S_EMIT;
            S_UP_RD: begin
                if (w_idx_inc < r_len) begin
                    n_state = S_UP_WR;
                end else begin
                    n_state = (r_per >= r_max) ? S_WALK_RD : S_EMIT;
                end
            end
            S_UP_WR:   n_state = S_UP_RD;
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = r_res.last ? S_IDLE : S_WALK_RD;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Memory ports, divider requests and handshakes.
    always_comb begin
        w_ord_raddr  = r_idx[SLOT_W-1:0];
        w_ord_waddr  = r_idx[SLOT_W-1:0];
        w_ord_wdata  = r_ord_q;
        w_ord_we     = 1'b0;
        w_task_raddr = r_cur;
        w_task_we    = 1'b0;
        o_div        = '{start: 1'b0, dividend: r_max, divisor: r_tp};
        o_in_ready   = 1'b0;
        o_res_valid  = 1'b0;
        unique case (r_state)
            S_IDLE:     o_in_ready = 1'b1;
            S_DEL_RD:   w_task_raddr = r_slot;
            S_LIM:      o_div.start = 1'b1;
            S_WALK_ORD: w_task_raddr = r_ord_q;
            S_WALK_TSK: begin
                if (r_walk == W_TICK) begin
                    o_div = '{start: 1'b1, dividend: w_q_period, divisor: r_tp};
                end
            end
            S_DIV_TT: begin
                o_div = '{start: i_div.done, dividend: r_tick_cnt, divisor: w_tt};
            end
            S_DN_RD:    w_ord_raddr = w_idx_dec[SLOT_W-1:0];
            S_DN_WR:    w_ord_we = 1'b1;
            S_INSERT: begin
                w_ord_we    = 1'b1;
                w_ord_waddr = r_pos[SLOT_W-1:0];
                w_ord_wdata = r_slot;
                w_task_we   = 1'b1;
            end
            S_UP_RD:    w_ord_raddr = w_idx_inc[SLOT_W-1:0];
            S_UP_WR:    w_ord_we = 1'b1;
            S_EMIT:     o_res_valid = 1'b1;
            default: begin
            end
        endcase
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (w_ord_we) begin
            r_order_mem[w_ord_waddr] <= w_ord_wdata;
        end
        r_ord_q <= r_order_mem[w_ord_raddr];
        if (w_task_we) begin
            r_task_mem[r_slot] <= {r_per, r_pri};
        end
        r_task_q <= r_task_mem[w_task_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_len        <= '0;
            r_active     <= '0;
            r_susp       <= '0;
            r_ready      <= '0;
            r_tick_cnt   <= '0;
            r_max        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_slot       <= i_slot;
                        r_per        <= i_period;
                        r_pri        <= i_prio;
                        r_tp         <= (i_tick_period == '0) ? PERIOD_W'(1) : i_tick_period;
                        r_idx        <= '0;
                        r_pend_valid <= 1'b0;
                        r_res        <= '{status: w_idle_st, dispatched: 1'b0,
                                          task_slot: '0, last: 1'b1};
                        unique case (w_cmd)
                            CMD_TICK:   r_walk <= W_TICK;
                            CMD_START:  r_walk <= W_START;
                            CMD_DELETE: r_walk <= W_DELETE;
                            CMD_SUSPEND, CMD_RESUME: begin
                                if (r_active[i_slot]) begin
                                    r_susp[i_slot] <= (w_cmd == CMD_SUSPEND);
                                end
                            end
                            CMD_SCHEDULE: r_walk <= W_SCHED;
                            default: begin
                            end
                        endcase
                    end
                end
                S_DEL_PER: r_per <= w_q_period;
                S_LIM_W: begin
                    if (i_div.done) begin
                        r_limit    <= i_div.quot;
                        r_tick_cnt <= r_tick_cnt + 1'b1;
                    end
                end
                S_WALK_RD: begin
                    if (w_walk_end) begin
                        unique case (r_walk)
                            W_START:  r_pos <= r_len;
                            W_DELETE: r_res.status <= ST_UNLISTED;
                            W_TICK: begin
                                if (r_tick_cnt >= r_limit) begin
                                    r_tick_cnt <= '0;
                                end
                            end
                            W_SCHED: begin
                                r_res <= '{status: ST_OK, dispatched: r_pend_valid,
                                           task_slot: r_pend_valid ? r_pend_slot : '0,
                                           last: 1'b1};
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_WALK_ORD: begin
                    r_cur <= r_ord_q;
                    unique case (r_walk)
                        W_DELETE: begin
                            if (r_ord_q == r_slot) begin
                                r_pos <= r_idx;
                            end else begin
                                r_idx <= w_idx_inc;
                            end
                        end
                        W_SCHED: begin
                            r_idx <= w_idx_inc;
                            if (r_ready[r_ord_q]) begin
                                r_ready[r_ord_q] <= 1'b0;
                                r_pend_slot      <= r_ord_q;
                                r_pend_valid     <= 1'b1;
                                if (r_pend_valid) begin
                                    r_res <= '{status: ST_OK, dispatched: 1'b1,
                                               task_slot: r_pend_slot, last: 1'b0};
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_WALK_TSK: begin
                    unique case (r_walk)
                        W_START: begin
                            if (w_q_prio > r_pri) begin
                                r_pos <= r_idx;
                                r_idx <= r_len;
                            end else begin
                                r_idx <= w_idx_inc;
                            end
                        end
                        W_MAX: begin
                            if (!r_susp[r_cur] && w_q_period > r_max) begin
                                r_max <= w_q_period;
                            end
                            r_idx <= w_idx_inc;
                        end
                        default: begin
                        end
                    endcase
                end
                S_DIV_MOD: begin
                    if (i_div.done) begin
                        if (i_div.rem == '0 && !r_susp[r_cur]) begin
                            r_ready[r_cur] <= 1'b1;
                        end
                        r_idx <= w_idx_inc;
                    end
                end
                S_DN_WR: r_idx <= w_idx_dec;
                S_INSERT: begin
                    r_len            <= r_len + 1'b1;
                    r_active[r_slot] <= 1'b1;
                    r_susp[r_slot]   <= 1'b0;
                    r_ready[r_slot]  <= 1'b0;
                    if (r_per > r_max) begin
                        r_max <= r_per;
                    end
                end
                S_UP_RD: begin
                    if (!(w_idx_inc < r_len)) begin
                        r_len            <= r_len - 1'b1;
                        r_active[r_slot] <= 1'b0;
                        r_susp[r_slot]   <= 1'b0;
                        r_ready[r_slot]  <= 1'b0;
                        if (r_per >= r_max) begin
                            r_max  <= '0;
                            r_idx  <= '0;
                            r_walk <= W_MAX;
                        end
                    end
                end
                S_UP_WR: r_idx <= w_idx_inc;
                default: begin
                end
            endcase
        end
    end

    `PTRS_ASSERT(a_len_matches_active, $countones(r_active) == r_len, "list length drift")
    `PTRS_ASSERT(a_susp_needs_active, (r_susp & ~r_active) == '0, "suspended slot not active")
    `PTRS_ASSERT(a_ready_needs_active, (r_ready & ~r_active) == '0, "ready slot not active")
    `PTRS_ASSERT_ALWAYS(a_reset_clears_len, !i_rst_n |=> (r_len == '0), "length kept over reset")

endmodule

FILE: rtl/periodic_task_ready_scheduler.sv
// Periodic task ready scheduler. Each input transaction carries one command in s_axis_tuser
// (tick, start, delete, suspend, resume, schedule) and answers with one output transaction,
// except schedule, which returns one transaction per ready task in priority order (tlast on
// the final one) or a single transaction with dispatched low when nothing is ready. Commands
// are processed one at a time by a sequencer that walks the priority-ordered slot list held
// in a small synchronous memory, with the task periods and priorities in a second one. Suspend,
// resume and rejected commands finish without a walk; schedule walks every listed slot and
// emits one result per ready task; start searches the list for its place and then moves the
// entries below it; delete searches for its slot, moves the entries after it and, when the
// largest period goes, walks the list once more to find the new one. Tick dominates: the
// shared radix-4 divider computes every quotient, and every listed slot needs two quotients
// on top of the one for the tick limit.
// A new command is taken while the previous result still waits in the output register.
module periodic_task_ready_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] slot, [18:3] period, [26:19] priority_req, [42:27] tick_period, [47:43] zero.
    input  logic [47:0] s_axis_tdata,
    // [2:0] cmd.
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [2] dispatched, [5:3] task_slot, [7:6] zero.
    output logic [7:0]  m_axis_tdata,
    // last.
    output logic        m_axis_tlast
);
    import ptrs_pkg::*;

    `include "assert_macros.svh"

    t_result  w_res;
    logic     w_res_valid;
    logic     w_res_ready;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    logic     r_out_valid;
    t_result  r_out;

    ptrs_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_cmd         (s_axis_tuser),
        .i_slot        (s_axis_tdata[2:0]),
        .i_period      (s_axis_tdata[18:3]),
        .i_prio        (s_axis_tdata[26:19]),
        .i_tick_period (s_axis_tdata[42:27]),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_res         (w_res),
        .o_div         (w_div_req),
        .i_div         (w_div_rsp)
    );

    ptrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Output register: the core hands over a result whenever the register is empty or
    // being drained in the same cycle.
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.task_slot, r_out.dispatched, r_out.status};
    assign m_axis_tlast  = r_out.last;

endmodule
